>>> hdl/ria_pkg.sv
package ria_pkg;

    localparam int ID_W     = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ADDREF  = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_STILL_REF  = 3'd1,
        ST_EXHAUSTED  = 3'd2,
        ST_STACK_FULL = 3'd3,
        ST_SATURATED  = 3'd4
    } status_t;

    // control from the sequencer to the count table
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } cnt_ctl_t;

endpackage

>>> hdl/ria_ram.sv
module ria_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/ria_cnt_table.sv
module ria_cnt_table #(
    parameter int DEPTH      = 256,
    parameter int COUNT_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ria_pkg::cnt_ctl_t        ctl,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [COUNT_BITS-1:0]    wr_data,
    output logic [COUNT_BITS-1:0]    rd_count
);

    logic [DEPTH-1:0]      valid_reg;
    logic                  rd_valid_reg;
    logic [COUNT_BITS-1:0] ram_q;

    ria_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // an entry never written since reset reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_count = rd_valid_reg ? ram_q : '0;

endmodule

>>> hdl/refcounted_id_allocator_unit.sv
// Reference-counted id allocator with a LIFO free list.
// Input channel (s_valid/s_ready): s_op selects allocate, release or add
// reference; s_id names the id for release and add reference.
// Result channel (m_valid/m_ready): one transaction per request, carrying
// m_id_out (the allocated id, zero if none is left, else the request id) and m_status.
// On accept, the unit issues the reads of the free stack and the count table;
// in S_EXEC it then computes, writes the free stack and count table back as
// the op needs, and loads the output register. The memory reads are registered,
// and s_ready stays low until the current request finishes.
// A result waiting in the output register does not block the next accept;
// if it is still not taken when the next request is ready to finish, that
// request holds in S_EXEC until m_ready frees the register.
// Reset (aresetn, synchronous, active low) empties the free stack, restarts
// fresh ids at 1 and marks every count entry as zero through per-entry
// valid bits, so no clearing pass is needed and s_ready is high right after.
module refcounted_id_allocator_unit #(
    parameter int ID_COUNT   = 256,
    parameter int COUNT_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ria_pkg::OP_W-1:0]       s_op,
    input  logic [ria_pkg::ID_W-1:0]       s_id,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ria_pkg::ID_W-1:0]       m_id_out,
    output logic [ria_pkg::STATUS_W-1:0]   m_status
);

    localparam int CNT_DEPTH = (ID_COUNT < (1 << ria_pkg::ID_W)) ? ID_COUNT
                                                                 : (1 << ria_pkg::ID_W);
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int STK_AW    = $clog2(ID_COUNT);
    localparam int SP_W      = $clog2(ID_COUNT + 1);
    localparam int RANGE_W   = 18;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_TWO = COUNT_BITS'(2);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [ria_pkg::OP_W-1:0] op_reg;
    logic [ria_pkg::ID_W-1:0] id_reg;
    logic                     in_range_reg;
    logic [SP_W-1:0]          sp_reg, sp_next;
    logic [SP_W-1:0]          fresh_reg, fresh_next;

    logic                            m_valid_reg, m_valid_next;
    logic [ria_pkg::ID_W-1:0]        m_id_out_reg, m_id_out_next;
    ria_pkg::status_t                m_status_reg, m_status_next;

    logic                     accept;
    logic                     finish;
    logic                     stk_wr_en;
    logic [ria_pkg::ID_W-1:0] stk_rd_data;
    logic [STK_AW-1:0]        stk_rd_addr;

    ria_pkg::cnt_ctl_t        cnt_ctl;
    logic                     cnt_wr_en;
    logic [COUNT_BITS-1:0]    cnt_wr_data;
    logic [COUNT_BITS-1:0]    cnt_rd;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign finish  = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    assign stk_rd_addr = STK_AW'(sp_reg - SP_W'(1));

    ria_ram #(
        .WIDTH(ria_pkg::ID_W),
        .DEPTH(ID_COUNT)
    ) u_free_stack (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (STK_AW'(sp_reg)),
        .wr_data (id_reg),
        .rd_en   (accept),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    assign cnt_ctl.rd_en = accept;
    assign cnt_ctl.wr_en = cnt_wr_en;

    ria_cnt_table #(
        .DEPTH      (CNT_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_cnt_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (cnt_ctl),
        .rd_addr  (CNT_AW'(s_id)),
        .wr_addr  (CNT_AW'(id_reg)),
        .wr_data  (cnt_wr_data),
        .rd_count (cnt_rd)
    );

    always_comb begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        fresh_next    = fresh_reg;
        stk_wr_en     = 1'b0;
        cnt_wr_en     = 1'b0;
        cnt_wr_data   = '0;
        m_id_out_next = m_id_out_reg;
        m_status_next = m_status_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (finish) begin
                    state_next    = S_IDLE;
                    m_valid_next  = 1'b1;
                    m_id_out_next = id_reg;
                    m_status_next = ria_pkg::ST_OK;
                    unique case (ria_pkg::op_t'(op_reg))
                        ria_pkg::OP_ALLOC: begin
                            if (sp_reg != '0) begin
                                sp_next       = sp_reg - SP_W'(1);
                                m_id_out_next = stk_rd_data;
                            end else if (fresh_reg < SP_W'(ID_COUNT)) begin
                                m_id_out_next = ria_pkg::ID_W'(fresh_reg);
                                fresh_next    = fresh_reg + SP_W'(1);
                            end else begin
                                m_id_out_next = '0;
                                m_status_next = ria_pkg::ST_EXHAUSTED;
                            end
                        end
                        ria_pkg::OP_RELEASE: begin
                            if (in_range_reg) begin
                                cnt_wr_en = 1'b1;
                                if (cnt_rd >= COUNT_TWO) begin
                                    // holders remain: keep the id
                                    cnt_wr_data   = cnt_rd - COUNT_BITS'(1);
                                    m_status_next = ria_pkg::ST_STILL_REF;
                                end else if (sp_reg >= SP_W'(ID_COUNT)) begin
                                    // drop the id, entry stays cleared
                                    m_status_next = ria_pkg::ST_STACK_FULL;
                                end else begin
                                    stk_wr_en = 1'b1;
                                    sp_next   = sp_reg + SP_W'(1);
                                end
                            end
                        end
                        ria_pkg::OP_ADDREF: begin
                            if (in_range_reg) begin
                                if (cnt_rd == '0) begin
                                    cnt_wr_en   = 1'b1;
                                    cnt_wr_data = COUNT_TWO;
                                end else if (cnt_rd == COUNT_MAX) begin
                                    m_status_next = ria_pkg::ST_SATURATED;
                                end else begin
                                    cnt_wr_en   = 1'b1;
                                    cnt_wr_data = cnt_rd + COUNT_BITS'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            fresh_reg   <= SP_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= s_op;
            id_reg       <= s_id;
            in_range_reg <= (RANGE_W'(s_id) < RANGE_W'(ID_COUNT));
        end
        m_id_out_reg <= m_id_out_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_id_out = m_id_out_reg;
    assign m_status = m_status_reg;

endmodule
